@@ hw/rtl/sha1h_pkg.sv @@
// sha1h_pkg: shared types and constants of the sha-1 hash core
// no dependencies; imported by every module of the core
`timescale 1ns / 1ps

package sha1h_pkg;

	typedef logic [31:0] word_t;

	// initial chaining values
	localparam word_t H0 = 32'h67452301;
	localparam word_t H1 = 32'hEFCDAB89;
	localparam word_t H2 = 32'h98BADCFE;
	localparam word_t H3 = 32'h10325476;
	localparam word_t H4 = 32'hC3D2E1F0;

	// round constants
	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [2:0] WORD_LAST  = 3'd4;

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_BYTE,
		KIND_LAST_BYTE,
		KIND_LAST_EMPTY
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	typedef enum logic [2:0] {
		ST_DATA,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_ROUND,
		ST_ADD,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/sha1h_front.sv @@
// sha1h_front: request intake, classifies each item and drops idle ones
// depends on sha1h_pkg
`timescale 1ns / 1ps

module sha1h_front import sha1h_pkg::*; (
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] data_byte,
	input  logic       has_data,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output item_t      push_item
);

	kind_t kind;

	always_comb begin
		unique case ({last_byte, has_data})
			2'b01:   kind = KIND_BYTE;
			2'b11:   kind = KIND_LAST_BYTE;
			2'b10:   kind = KIND_LAST_EMPTY;
			default: kind = KIND_IDLE;
		endcase
	end

	assign item_ready     = !q_full;
	// idle requests are taken but never queued
	assign push           = item_valid && !q_full && (kind != KIND_IDLE);
	assign push_item.kind = kind;
	assign push_item.data = data_byte;

endmodule

@@ hw/rtl/sha1h_queue.sv @@
// sha1h_queue: small fifo of classified requests between intake and engine
// depends on sha1h_pkg
`timescale 1ns / 1ps

module sha1h_queue import sha1h_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_pop;

	assign full   = (cnt_q == CW'(DEPTH));
	assign valid  = (cnt_q != '0);
	assign item   = mem_q[rd_ptr_q];
	assign do_pop = pop && valid;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/sha1h_back.sv @@
// sha1h_back: byte packing, padding sequencer, 80-round compression and digest output
// depends on sha1h_pkg
`timescale 1ns / 1ps

module sha1h_back import sha1h_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        pop,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	state_t       state_q, state_d;
	state_t       ret_q, ret_d;
	logic [6:0]   rnd_q;
	logic [5:0]   pos_q;
	logic [63:0]  byte_cnt_q;
	word_t        chain_q [5];

	word_t        acc_q;
	word_t        w_q [16];
	word_t        a_q, b_q, c_q, d_q, e_q;

	word_t        dig_q [5];
	logic         out_busy_q;
	logic [2:0]   out_idx_q;

	logic         push;
	logic [7:0]   push_byte;
	logic         cnt_inc;
	logic         load_out;
	logic         start_cmp;
	logic         out_take;

	logic [63:0]  len_bits;
	logic [2:0]   len_sel;
	logic [7:0]   len_byte;
	word_t        f, k, wt, sched, tmp, new_word;

	// big-endian bit count, most significant byte at block position 56
	assign len_bits = {byte_cnt_q[60:0], 3'b000};
	assign len_sel  = 3'd7 - pos_q[2:0];
	assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
			ret_q   <= ST_DATA;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		pop       = 1'b0;
		push      = 1'b0;
		push_byte = 8'h00;
		cnt_inc   = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_DATA: begin
				if (q_valid) begin
					pop = 1'b1;
					unique case (q_item.kind)
						KIND_BYTE: begin
							push      = 1'b1;
							push_byte = q_item.data;
							cnt_inc   = 1'b1;
						end
						KIND_LAST_BYTE: begin
							push      = 1'b1;
							push_byte = q_item.data;
							cnt_inc   = 1'b1;
							state_d   = ST_PAD80;
						end
						KIND_LAST_EMPTY: begin
							state_d = ST_PAD80;
						end
						KIND_IDLE: begin
						end
					endcase
				end
			end
			ST_PAD80: begin
				push      = 1'b1;
				push_byte = PAD_BYTE;
				state_d   = ST_PADZ;
			end
			ST_PADZ: begin
				if (pos_q == LEN_POS) begin
					state_d = ST_PADLEN;
				end else begin
					push = 1'b1;
				end
			end
			ST_PADLEN: begin
				push      = 1'b1;
				push_byte = len_byte;
			end
			ST_ROUND: begin
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ret_q;
			end
			ST_DONE: begin
				if (!out_busy_q) begin
					load_out = 1'b1;
					state_d  = ST_DATA;
				end
			end
			default: begin
				state_d = ST_DATA;
			end
		endcase
		// block full: compress, then resume, or after the length block output the digest
		if (push && (pos_q == BLOCK_LAST)) begin
			ret_d   = (state_q == ST_PADLEN) ? ST_DONE : state_d;
			state_d = ST_ROUND;
		end
	end

	assign start_cmp = push && (pos_q == BLOCK_LAST);
	assign new_word  = {acc_q[23:0], push_byte};

	// round function
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
	end

	assign sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign wt    = (rnd_q < 7'd16) ? w_q[0] : {sched[30:0], sched[31]};
	assign tmp   = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;

	// message schedule line: word 0 leaves, the newest word enters at 15
	always_ff @(posedge clk) begin
		if (push) begin
			acc_q <= new_word;
		end
		if ((push && (pos_q[1:0] == 2'd3)) || (state_q == ST_ROUND)) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= (state_q == ST_ROUND) ? wt : new_word;
		end
		if (start_cmp) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_ROUND) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= tmp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q      <= '0;
			pos_q      <= '0;
			byte_cnt_q <= '0;
			chain_q[0] <= H0;
			chain_q[1] <= H1;
			chain_q[2] <= H2;
			chain_q[3] <= H3;
			chain_q[4] <= H4;
		end else begin
			if (start_cmp) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (push) begin
				pos_q <= pos_q + 1'b1;
			end
			if (load_out) begin
				byte_cnt_q <= '0;
			end else if (cnt_inc) begin
				byte_cnt_q <= byte_cnt_q + 1'b1;
			end
			if (state_q == ST_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end else if (load_out) begin
				chain_q[0] <= H0;
				chain_q[1] <= H1;
				chain_q[2] <= H2;
				chain_q[3] <= H3;
				chain_q[4] <= H4;
			end
		end
	end

	// digest buffer drains on its own so the next message can start
	assign out_take = out_busy_q && digest_ready;

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int i = 0; i < 5; i++) begin
				dig_q[i] <= chain_q[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			if (load_out) begin
				out_busy_q <= 1'b1;
				out_idx_q  <= '0;
			end else if (out_take) begin
				if (out_idx_q == WORD_LAST) begin
					out_busy_q <= 1'b0;
				end
				out_idx_q <= out_idx_q + 1'b1;
			end
		end
	end

	assign digest_valid = out_busy_q;
	assign digest_word  = dig_q[0];
	assign word_index   = out_idx_q;
	assign last_word    = (out_idx_q == WORD_LAST);

endmodule

@@ hw/rtl/sha1_hash_core.sv @@
// sha1_hash_core: top level of the byte-serial sha-1 hash core
// depends on sha1h_pkg, sha1h_front, sha1h_queue, sha1h_back
`timescale 1ns / 1ps
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  item     | item_valid / item_ready    | data_byte[7:0], has_data, last_byte
//  digest   | digest_valid / digest_ready| digest_word[31:0], word_index[2:0],
//           |                            | last_word
//
//  a message byte is packed into the schedule line; each 64th byte starts 80
//  rounds plus one chaining add in the single shared round unit, which holds
//  byte intake until the block is compressed.
//  the last request adds the padding bytes (9 to 72), a step to reach the
//  length field, the rounds of the one or two final blocks and a load of the
//  digest buffer; the five words then drain at one a cycle while digest_ready is high.
//  reset loads the initial chaining values, clears length and queue; no clearing pass.
//  the request queue keeps taking requests until full while the engine runs, and the
//  digest buffer lets the next message start while words wait to be taken.

module sha1_hash_core import sha1h_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_data,
	input  logic        last_byte,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic  q_full;
	logic  q_push;
	item_t q_push_item;
	logic  q_pop;
	logic  q_valid;
	item_t q_item;

	sha1h_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.data_byte  (data_byte),
		.has_data   (has_data),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (q_push),
		.push_item  (q_push_item)
	);

	sha1h_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.item      (q_item)
	);

	sha1h_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (q_pop),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

endmodule

@@ hw/rtl/sha1h_check.sv @@
// sha1h_check: port-level checks of the digest channel, bound to sha1_hash_core
// depends on sha1_hash_core
`timescale 1ns / 1ps

module sha1h_check (
	input logic        clk,
	input logic        arst_n,
	input logic        digest_valid,
	input logic        digest_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=>
			digest_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest word changed while stalled");

	// a digest always opens with word 0
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> (word_index == 3'd0))
		else $error("digest did not start at word 0");

	// words follow back to back in order
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && !last_word |=>
			digest_valid && (word_index == $past(word_index) + 3'd1))
		else $error("digest word missing or out of order");

	// last flag marks exactly the fifth word
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (last_word == (word_index == 3'd4)))
		else $error("last_word disagrees with word_index");

	// a new digest never follows the last word in the next cycle
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && last_word |=> !digest_valid)
		else $error("digest buffer reloaded while draining");

endmodule

bind sha1_hash_core sha1h_check u_check (.*);
